FILE: design/crc32sic_pkg.sv
package crc32sic_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

    localparam int unsigned CRC_W  = 32;
    localparam int unsigned SIZE_W = 64;
    localparam int unsigned CFG_W  = 64;

    // configuration register indexes
    localparam logic CFG_EXPECTED_CRC  = 1'b0;
    localparam logic CFG_EXPECTED_SIZE = 1'b1;

    typedef enum logic [1:0] {
        ST_PASS     = 2'd0,
        ST_SIZE_ERR = 2'd1,
        ST_CRC_ERR  = 2'd2
    } t_status;

    // one input item as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_item;

    // one result item
    typedef struct packed {
        logic [SIZE_W-1:0] current_size;
        logic [CRC_W-1:0]  current_crc;
        t_status           status;
    } t_result;

    // reflected crc-32, one byte folded in
    function automatic logic [CRC_W-1:0] crc32_byte(
        input logic [CRC_W-1:0] acc,
        input logic [7:0]       b
    );
        logic [CRC_W-1:0] v;
        v = {24'h00_0000, acc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v ^ (acc >> 8);
    endfunction

endpackage

FILE: design/crc32sic_acc.sv
module crc32sic_acc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  crc32sic_pkg::t_item           i_item,
    input  logic [crc32sic_pkg::CRC_W-1:0]  i_exp_crc,
    input  logic [crc32sic_pkg::SIZE_W-1:0] i_exp_size,
    output crc32sic_pkg::t_result         o_result
);
    import crc32sic_pkg::*;

    logic [CRC_W-1:0]  r_crc;
    logic [SIZE_W-1:0] r_count;
    logic [CRC_W-1:0]  n_crc;
    logic [SIZE_W-1:0] n_count;
    logic [CRC_W-1:0]  final_crc;

    // fold the byte in when one is present
    always_comb begin
        if (i_item.byte_valid) begin
            n_crc   = crc32_byte(r_crc, i_item.data_byte);
            n_count = r_count + 64'd1;
        end else begin
            n_crc   = r_crc;
            n_count = r_count;
        end
    end

    assign final_crc = n_crc ^ CRC_PRESET;

    // size check wins over crc check
    always_comb begin
        o_result.current_crc  = final_crc;
        o_result.current_size = n_count;
        priority if (i_exp_size != '0 && n_count != i_exp_size) begin
            o_result.status = ST_SIZE_ERR;
        end else if (final_crc != i_exp_crc) begin
            o_result.status = ST_CRC_ERR;
        end else begin
            o_result.status = ST_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_PRESET;
            r_count <= '0;
        end else if (i_step) begin
            if (i_item.last) begin
                r_crc   <= CRC_PRESET;
                r_count <= '0;
            end else begin
                r_crc   <= n_crc;
                r_count <= n_count;
            end
        end
    end

    a_preset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.last) |=> (r_crc == CRC_PRESET && r_count == '0))
        else $error("accumulators not preset after end of file");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_step) |=> ($stable(r_crc) && $stable(r_count)))
        else $error("accumulators changed without a step");

    a_count_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.byte_valid && !i_item.last)
            |=> (r_count == $past(r_count) + 64'd1))
        else $error("byte count did not advance by one");

endmodule

FILE: design/crc32_stream_integrity_check_unit.sv
// an input transfer with tlast reaches the result on the master side through the input
// register, then the result register; other transfers produce no result
// throughput: one byte per cycle, limited by the byte-wide crc update loop;
// a stalled result only holds back an item marked last; plain bytes keep flowing
// reset (synchronous, active low): pipeline empty, crc preset to all ones, count zero,
// expected crc and expected size cleared
module crc32_stream_integrity_check_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]   i_s_axis_tuser,   // [0] byte_valid
    input  logic         i_s_axis_tlast,   // last
    // master side
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata,   // [1:0] status, [33:2] current_crc,
                                           // [97:34] current_size, [103:98] zero
    // configuration writes
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    import crc32sic_pkg::*;

    // configuration registers
    logic [CRC_W-1:0]  r_exp_crc;
    logic [SIZE_W-1:0] r_exp_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_crc  <= '0;
            r_exp_size <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXPECTED_CRC:  r_exp_crc  <= i_cfg_data[CRC_W-1:0];
                CFG_EXPECTED_SIZE: r_exp_size <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic    r_s1_valid;
    t_item   r_s1_item;
    logic    out_free;
    logic    s1_advance;
    logic    s_xfer;
    t_result step_result;

    // result register
    logic    r_out_valid;
    t_result r_out_result;

    // result slot can take a new result this cycle
    assign out_free   = !r_out_valid || i_m_axis_tready;
    // bytes without last never wait on the result slot
    assign s1_advance = r_s1_valid && (!r_s1_item.last || out_free);
    assign o_s_axis_tready = !r_s1_valid || s1_advance;
    assign s_xfer     = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_s1_item.data_byte  <= i_s_axis_tdata;
            r_s1_item.byte_valid <= i_s_axis_tuser[0];
            r_s1_item.last       <= i_s_axis_tlast;
        end
    end

    // running crc and byte count, result formed on the last item
    crc32sic_acc u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (s1_advance),
        .i_item     (r_s1_item),
        .i_exp_crc  (r_exp_crc),
        .i_exp_size (r_exp_size),
        .o_result   (step_result)
    );

    logic n_out_valid;

    always_comb begin
        n_out_valid = r_out_valid && !i_m_axis_tready;
        if (s1_advance && r_s1_item.last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_item.last) begin
            r_out_result <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b00_0000, r_out_result.current_size,
                              r_out_result.current_crc, r_out_result.status};

    a_out_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_last_blocks_on_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_item.last && r_out_valid && !i_m_axis_tready)
            |-> !o_s_axis_tready)
        else $error("input taken while end of file waits on a full result slot");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_s1_valid && r_s1_item.last))
        else $error("result appeared without an end of file item");

    a_plain_byte_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_item.last) |-> o_s_axis_tready)
        else $error("plain byte stalled the input");

endmodule
